// File: rtl/sm_pkg.sv
package sm_pkg;

	localparam int MAX_RINGS    = 64;
	localparam int MAX_SEGMENTS = 64;
	localparam int IDX_W        = 12;

	// sine series coefficients, Q30 with a quarter turn as 1.0
	localparam logic [30:0] SC1     = 31'd1686629713;
	localparam logic [30:0] SC3     = 31'd693598668;
	localparam logic [30:0] SC5     = 31'd85569306;
	localparam logic [30:0] SC7     = 31'd5026996;
	localparam logic [30:0] SC9     = 31'd172272;
	localparam logic [30:0] Q30_ONE = 31'h4000_0000;

	typedef logic [IDX_W-1:0] idx_t;

	typedef enum logic [1:0] {
		REG_RADIUS   = 2'd0,
		REG_RINGS    = 2'd1,
		REG_SEGMENTS = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic       hv;
		logic [1:0] ntri;
		idx_t       t0a;
		idx_t       t0b;
		idx_t       t0c;
		idx_t       t1a;
		idx_t       t1b;
		idx_t       t1c;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
	} meta_t;

	typedef struct packed {
		logic signed [16:0] pa;
		logic signed [16:0] pb;
		logic signed [16:0] pc;
		logic signed [15:0] nx;
		logic signed [15:0] ny;
		logic signed [15:0] nz;
	} vtx_t;

endpackage

// File: rtl/sm_div.sv
module sm_div (
	input  logic        clk,
	input  logic        en,
	input  logic        half,
	input  logic [6:0]  num,
	input  logic [6:0]  div,
	output logic [32:0] quo,
	output logic [6:0]  rem16,
	output logic [6:0]  remf
);
	import sm_pkg::*;

	typedef struct packed {
		logic [6:0] rem;
		logic [6:0] rem7;
		logic [7:0] bits;
	} div8_t;

	// eight restoring steps, remainder stays below the divisor
	function automatic div8_t div_step8(logic [6:0] r_in, logic [6:0] d);
		div8_t      o;
		logic [7:0] t;
		logic [6:0] r;
		r = r_in;
		o = '0;
		for (int k = 0; k < 8; k++) begin
			t = {r, 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				o.bits[7-k] = 1'b1;
			end
			r = t[6:0];
			if (k == 6) begin
				o.rem7 = r;
			end
		end
		o.rem = r;
		return o;
	endfunction

	logic        qi;
	logic [6:0]  r0;
	div8_t       d1, d2, d3, d4;
	logic [6:0]  rem_s1, rem_s2, rem_s3, r16_s3;
	logic [8:0]  quo_s1;
	logic [16:0] quo_s2;
	logic [24:0] quo_s3;

	always_comb begin
		qi = (num >= div);
		r0 = qi ? (num - div) : num;
		d1 = div_step8(r0, div);
		d2 = div_step8(rem_s1, div);
		d3 = div_step8(rem_s2, div);
		d4 = div_step8(rem_s3, div);
	end

	// remf: remainder after 31 fraction bits when half is set, else after 32
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= d1.rem;
			quo_s1 <= {qi, d1.bits};
			rem_s2 <= d2.rem;
			quo_s2 <= {quo_s1, d2.bits};
			rem_s3 <= d3.rem;
			quo_s3 <= {quo_s2, d3.bits};
			r16_s3 <= rem_s2;
			quo    <= {quo_s3, d4.bits};
			remf   <= half ? d4.rem7 : d4.rem;
			rem16  <= r16_s3;
		end
	end

endmodule

// File: rtl/sm_sine.sv
module sm_sine (
	input  logic        clk,
	input  logic        en,
	input  logic [31:0] ang,
	output logic [30:0] mag,
	output logic        neg
);
	import sm_pkg::*;

	function automatic logic [30:0] horner(logic [30:0] z2, logic [30:0] acc, logic [30:0] c);
		logic [61:0] p;
		p = z2 * acc;
		return c - p[60:30];
	endfunction

	logic [31:0] u;
	logic [61:0] pz2, ps;
	logic [30:0] sv;
	logic [30:0] z_s1, z_s2, z_s3, z_s4, z_s5, z_s6;
	logic [30:0] z2_s2, z2_s3, z2_s4, z2_s5;
	logic [30:0] acc_s3, acc_s4, acc_s5, acc_s6;
	logic        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6;

	always_comb begin
		u = {1'b0, ang[30:0]};
		if (u > 32'h4000_0000) begin
			u = 32'h8000_0000 - u;
		end
		pz2 = z_s1 * z_s1;
		ps  = z_s6 * acc_s6;
		sv  = ps[60:30];
		if (sv > Q30_ONE) begin
			sv = Q30_ONE;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			z_s1   <= u[30:0];
			neg_s1 <= ang[31];
			z2_s2  <= pz2[60:30];
			z_s2   <= z_s1;
			neg_s2 <= neg_s1;
			acc_s3 <= horner(z2_s2, SC9, SC7);
			z2_s3  <= z2_s2;
			z_s3   <= z_s2;
			neg_s3 <= neg_s2;
			acc_s4 <= horner(z2_s3, acc_s3, SC5);
			z2_s4  <= z2_s3;
			z_s4   <= z_s3;
			neg_s4 <= neg_s3;
			acc_s5 <= horner(z2_s4, acc_s4, SC3);
			z2_s5  <= z2_s4;
			z_s5   <= z_s4;
			neg_s5 <= neg_s4;
			acc_s6 <= horner(z2_s5, acc_s5, SC1);
			z_s6   <= z_s5;
			neg_s6 <= neg_s5;
			mag    <= sv;
			neg    <= neg_s6 & (sv != 31'd0);
		end
	end

endmodule

// File: rtl/sm_outq.sv
module sm_outq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               ld,
	input  sm_pkg::vtx_t       vtx,
	input  sm_pkg::meta_t      meta,
	output logic               ready,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic signed [16:0] field_a,
	output logic signed [16:0] field_b,
	output logic signed [16:0] field_c,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               last
);
	import sm_pkg::*;

	vtx_t       vtx_q;
	meta_t      meta_q;
	logic [1:0] cnt_q, pos_q;
	logic       tsel;
	logic [1:0] tpos;

	assign out_valid = (cnt_q != 2'd0);
	assign ready     = (cnt_q == 2'd0) || (cnt_q == 2'd1 && !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
			pos_q <= 2'd0;
		end else if (ld) begin
			cnt_q <= {1'b0, meta.hv} + meta.ntri;
			pos_q <= 2'd0;
		end else if (out_valid && !out_stall) begin
			cnt_q <= cnt_q - 2'd1;
			pos_q <= pos_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			vtx_q  <= vtx;
			meta_q <= meta;
		end
	end

	always_comb begin
		tpos     = pos_q - {1'b0, meta_q.hv};
		tsel     = tpos[0];
		last     = (cnt_q == 2'd1);
		kind     = 1'b1;
		normal_x = '0;
		normal_y = '0;
		normal_z = '0;
		tex_u    = '0;
		tex_v    = '0;
		if (tsel) begin
			field_a = {5'd0, meta_q.t1a};
			field_b = {5'd0, meta_q.t1b};
			field_c = {5'd0, meta_q.t1c};
		end else begin
			field_a = {5'd0, meta_q.t0a};
			field_b = {5'd0, meta_q.t0b};
			field_c = {5'd0, meta_q.t0c};
		end
		if (meta_q.hv && pos_q == 2'd0) begin
			kind     = 1'b0;
			field_a  = vtx_q.pa;
			field_b  = vtx_q.pb;
			field_c  = vtx_q.pc;
			normal_x = vtx_q.nx;
			normal_y = vtx_q.ny;
			normal_z = vtx_q.nz;
			tex_u    = meta_q.tex_u;
			tex_v    = meta_q.tex_v;
		end
	end

endmodule

// File: rtl/sphere_mesh_generator.sv
// uv sphere mesh generator, one grid point per item, 15-stage pipeline plus output register
// throughput: one result per cycle on the output channel while out_stall is low;
// an item leaves 0 to 3 results, and the next item loads as the last one leaves the single result port
// reset: radius 256, rings 16, segments 16, pipeline and output register empty
module sphere_mesh_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [5:0]         grid_x,
	input  logic [6:0]         grid_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic signed [16:0] field_a,
	output logic signed [16:0] field_b,
	output logic signed [16:0] field_c,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic signed [15:0] normal_z,
	output logic [16:0]        tex_u,
	output logic [16:0]        tex_v,
	output logic               last
);
	import sm_pkg::*;

	// configuration registers
	logic [15:0] radius_q;
	logic [6:0]  rings_q, segments_q;
	logic [6:0]  rc, sc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q   <= 16'd256;
			rings_q    <= 7'd16;
			segments_q <= 7'd16;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_RADIUS:   radius_q   <= cfg_data;
				REG_RINGS:    rings_q    <= cfg_data[6:0];
				REG_SEGMENTS: segments_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// clamped grid size; the user must keep it stable while items are in flight, the block does not enforce it
	always_comb begin
		rc = rings_q;
		if (rings_q < 7'd2) rc = 7'd2;
		else if (rings_q > 7'(MAX_RINGS)) rc = 7'(MAX_RINGS);
		sc = segments_q;
		if (segments_q < 7'd3) sc = 7'd3;
		else if (segments_q > 7'(MAX_SEGMENTS)) sc = 7'(MAX_SEGMENTS);
	end

	// global advance: whole pipeline moves when the last stage can drain
	logic oq_ready, adv;
	logic vld_s [1:15];
	meta_t meta_s [2:15];

	assign adv      = !vld_s[15] || oq_ready;
	assign in_stall = !adv;

	// stage 1: capture the grid point
	logic [5:0] x_s1;
	logic [6:0] y_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			x_s1 <= grid_x;
			y_s1 <= grid_y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= 15; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= 15; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	// stage 2: record counts and triangle vertex indices
	meta_t       meta_c;
	logic        on_grid, pick;
	logic [6:0]  ym1, ym2, xn;
	logic [13:0] pc, pp;
	idx_t        bc, bp, prev, prevn, cur, curn;

	always_comb begin
		on_grid = ({1'b0, x_s1} < sc) && (y_s1 <= rc);
		pick    = ({1'b0, x_s1} == sc - 7'd1);
		ym1     = y_s1 - 7'd1;
		ym2     = y_s1 - 7'd2;
		pc      = ym1 * sc;
		pp      = ym2 * sc;
		// row bases; on the bottom row bc is the bottom pole index
		bc      = pc[IDX_W-1:0] + idx_t'(1);
		bp      = pp[IDX_W-1:0] + idx_t'(1);
		xn      = pick ? 7'd0 : {1'b0, x_s1} + 7'd1;
		prev    = bp + idx_t'(x_s1);
		prevn   = bp + idx_t'(xn);
		cur     = bc + idx_t'(x_s1);
		curn    = bc + idx_t'(xn);
		meta_c  = '0;
		meta_c.hv = ((x_s1 == 6'd0) && (y_s1 == 7'd0 || y_s1 == rc))
		            || (y_s1 != 7'd0 && y_s1 != rc);
		if (y_s1 == 7'd0) begin
			meta_c.ntri = 2'd0;
		end else if (y_s1 == 7'd1) begin
			// top cap fan
			meta_c.ntri = 2'd1;
			meta_c.t0a  = '0;
			meta_c.t0b  = cur;
			meta_c.t0c  = curn;
		end else if (y_s1 == rc) begin
			// bottom cap fan
			meta_c.ntri = 2'd1;
			meta_c.t0a  = prev;
			meta_c.t0b  = bc;
			meta_c.t0c  = prevn;
		end else begin
			meta_c.ntri = 2'd2;
			meta_c.t0a  = prev;
			meta_c.t0b  = cur;
			meta_c.t0c  = prevn;
			meta_c.t1a  = prevn;
			meta_c.t1b  = cur;
			meta_c.t1c  = curn;
		end
		if (!on_grid) begin
			meta_c.hv   = 1'b0;
			meta_c.ntri = 2'd0;
		end
	end

	// stages 2 to 5: fraction bits of x/segments and y/rings
	logic [32:0] qx, qy;
	logic [6:0]  rx16, rxf, ry16, ryf;

	sm_div u_div_x (
		.clk  (clk),
		.en   (adv),
		.half (1'b0),
		.num  ({1'b0, x_s1}),
		.div  (sc),
		.quo  (qx),
		.rem16(rx16),
		.remf (rxf)
	);

	sm_div u_div_y (
		.clk  (clk),
		.en   (adv),
		.half (1'b1),
		.num  (y_s1),
		.div  (rc),
		.quo  (qy),
		.rem16(ry16),
		.remf (ryf)
	);

	// stage 6: round half up from the remainders, angles in turns
	logic [6:0]  hx, hy;
	logic        rnd_th, rnd_ph, rnd_u, rnd_v;
	logic [31:0] th_s6, ph_s6;
	logic [16:0] tu_c, tv_c;

	always_comb begin
		hx     = sc >> 1;
		hy     = rc >> 1;
		rnd_th = ({1'b0, rxf} + {1'b0, hx}) >= {1'b0, sc};
		rnd_u  = ({1'b0, rx16} + {1'b0, hx}) >= {1'b0, sc};
		rnd_ph = ({1'b0, ryf} + {1'b0, hy}) >= {1'b0, rc};
		rnd_v  = ({1'b0, ry16} + {1'b0, hy}) >= {1'b0, rc};
		tu_c   = qx[32:16] + {16'd0, rnd_u};
		tv_c   = qy[32:16] + {16'd0, rnd_v};
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			th_s6 <= qx[31:0] + {31'd0, rnd_th};
			ph_s6 <= qy[32:1] + {31'd0, rnd_ph};
		end
	end

	// meta shift line, texcoords join at stage 6
	meta_t meta_tx;

	always_comb begin
		meta_tx       = meta_s[5];
		meta_tx.tex_u = tu_c;
		meta_tx.tex_v = tv_c;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s[2] <= meta_c;
			for (int k = 3; k <= 15; k++) begin
				if (k == 6) begin
					meta_s[k] <= meta_tx;
				end else begin
					meta_s[k] <= meta_s[k-1];
				end
			end
		end
	end

	// stages 7 to 13: four sine lanes, cosine is a quarter turn ahead
	logic [30:0] st, ct, sp, cp;
	logic        nst, nct, nsp, ncp;

	sm_sine u_sin_th (.clk(clk), .en(adv), .ang(th_s6), .mag(st), .neg(nst));
	sm_sine u_cos_th (.clk(clk), .en(adv), .ang(th_s6 + 32'h4000_0000), .mag(ct), .neg(nct));
	sm_sine u_sin_ph (.clk(clk), .en(adv), .ang(ph_s6), .mag(sp), .neg(nsp));
	sm_sine u_cos_ph (.clk(clk), .en(adv), .ang(ph_s6 + 32'h4000_0000), .mag(cp), .neg(ncp));

	// stage 14: normal magnitudes in q30
	logic [61:0] p0, p2;
	logic [30:0] m0_c, m2_c;
	logic [30:0] m_s14 [3];
	logic        ng_s14 [3];

	always_comb begin
		p0   = sp * st + 62'h2000_0000;
		p2   = sp * ct + 62'h2000_0000;
		m0_c = p0[60:30];
		m2_c = p2[60:30];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_s14[0]  <= m0_c;
			ng_s14[0] <= (nsp != nst) && (m0_c != 31'd0);
			m_s14[1]  <= cp;
			ng_s14[1] <= ncp;
			m_s14[2]  <= m2_c;
			ng_s14[2] <= (nsp != nct) && (m2_c != 31'd0);
		end
	end

	// stage 15: scale by radius, normals to q1.14
	logic [46:0] prod_s15 [3];
	logic [14:0] nrm_s15 [3];
	logic        ng_s15 [3];
	logic [31:0] nsum [3];
	logic [14:0] nrm_c [3];

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			nsum[k]  = {1'b0, m_s14[k]} + 32'h8000;
			nrm_c[k] = (nsum[k][31:16] > 16'd16384) ? 15'd16384 : nsum[k][30:16];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < 3; k++) begin
				prod_s15[k] <= radius_q * m_s14[k];
				nrm_s15[k]  <= nrm_c[k];
				ng_s15[k]   <= ng_s14[k];
			end
		end
	end

	// round positions, apply signs after rounding
	logic [46:0] psum [3];
	logic [16:0] pos [3];
	logic [16:0] penc [3];
	logic [15:0] nenc [3];
	vtx_t        vtx_c;

	always_comb begin
		for (int k = 0; k < 3; k++) begin
			psum[k] = prod_s15[k] + 47'h2000_0000;
			pos[k]  = psum[k][46:30];
			penc[k] = (ng_s15[k] && pos[k] != 17'd0) ? (17'd0 - pos[k]) : pos[k];
			nenc[k] = (ng_s15[k] && nrm_s15[k] != 15'd0) ? (16'd0 - {1'b0, nrm_s15[k]})
			                                             : {1'b0, nrm_s15[k]};
		end
		vtx_c.pa = penc[0];
		vtx_c.pb = penc[1];
		vtx_c.pc = penc[2];
		vtx_c.nx = nenc[0];
		vtx_c.ny = nenc[1];
		vtx_c.nz = nenc[2];
	end

	// output register: one record per cycle while out_stall is low, vertex first then triangles
	sm_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ld       (vld_s[15] && oq_ready),
		.vtx      (vtx_c),
		.meta     (meta_s[15]),
		.ready    (oq_ready),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind     (kind),
		.field_a  (field_a),
		.field_b  (field_b),
		.field_c  (field_c),
		.normal_x (normal_x),
		.normal_y (normal_y),
		.normal_z (normal_z),
		.tex_u    (tex_u),
		.tex_v    (tex_v),
		.last     (last)
	);

endmodule
